FILE: rtl/core/irwall_pkg.sv
// Shared types, widths and codes for the ambient-reject proximity filter.
// No dependencies; every other file of the block imports this package.
package irwall_pkg;

   localparam int ADC_BITS  = 12;
   localparam int CH_W      = 3;
   localparam int CNT_W     = 8;
   localparam int ALPHA_W   = 9;
   localparam int THR_W     = 12;
   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 3;
   localparam int SUM_W     = ADC_BITS + CNT_W;

   localparam int DEF_SENSOR_COUNT = 5;
   localparam int DEF_QUEUE_DEPTH  = 2;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_AMBIENT_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_COUNT  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_EMA_ALPHA     = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_FRONT_THR     = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_SIDE_THR      = CSR_IDX_W'(4);

   // register reset values
   localparam logic [CNT_W-1:0]   RST_AMBIENT_COUNT = CNT_W'(4);
   localparam logic [CNT_W-1:0]   RST_ACTIVE_COUNT  = CNT_W'(4);
   localparam logic [ALPHA_W-1:0] RST_EMA_ALPHA     = ALPHA_W'(128);
   localparam logic [THR_W-1:0]   RST_FRONT_THR     = THR_W'(2048);
   localparam logic [THR_W-1:0]   RST_SIDE_THR      = THR_W'(2048);

   // sensor channels
   localparam logic [CH_W-1:0] CH_RIGHT     = CH_W'(0);
   localparam logic [CH_W-1:0] CH_FRONT     = CH_W'(1);
   localparam logic [CH_W-1:0] CH_LEFT      = CH_W'(2);
   localparam logic [CH_W-1:0] CH_TOP_LEFT  = CH_W'(3);
   localparam logic [CH_W-1:0] CH_TOP_RIGHT = CH_W'(4);

   // sample phase
   localparam logic PH_AMBIENT = 1'b0;
   localparam logic PH_ACTIVE  = 1'b1;

   typedef struct packed {
      logic [CNT_W-1:0]   ambient_count;
      logic [CNT_W-1:0]   active_count;
      logic [ALPHA_W-1:0] ema_alpha;
      logic [THR_W-1:0]   front_thr;
      logic [THR_W-1:0]   side_thr;
   } cfg_type;

   // one completed group, handed from front to back
   typedef struct packed {
      logic [CH_W-1:0]  channel;
      logic             phase;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

FILE: rtl/core/irwall_if.sv
// Handshake channels of the proximity filter: sample request and result.
// Depends on irwall_pkg for field widths.
interface irwall_req_if import irwall_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CH_W-1:0]     channel;
   logic                phase;
   logic [ADC_BITS-1:0] adc_sample;

   modport source (output valid, output channel, output phase, output adc_sample,
                   input ready);
   modport sink   (input valid, input channel, input phase, input adc_sample,
                   output ready);
endinterface

interface irwall_rsp_if import irwall_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CH_W-1:0]     out_channel;
   logic [ADC_BITS-1:0] ambient_level;
   logic [ADC_BITS-1:0] raw_level;
   logic [ADC_BITS-1:0] filtered_level;
   logic                wall_seen;

   modport source (output valid, output out_channel, output ambient_level,
                   output raw_level, output filtered_level, output wall_seen,
                   input ready);
   modport sink   (input valid, input out_channel, input ambient_level,
                   input raw_level, input filtered_level, input wall_seen,
                   output ready);
endinterface

FILE: rtl/core/irwall_front.sv
// Front end: accepts sample beats, tracks the open group, emits completed groups.
// Depends on irwall_pkg and irwall_req_if.
module irwall_front import irwall_pkg::*; #(
   parameter int SENSOR_COUNT = DEF_SENSOR_COUNT
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   irwall_req_if.sink req,
   input  q_stat_type q_stat,
   output logic       push,
   output job_type    push_job
);

   logic [CH_W-1:0]  chan_ff,  chan_in;
   logic             phase_ff, phase_in;
   logic [SUM_W-1:0] sum_ff,   sum_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             take;
   logic             in_range;
   logic             new_group;
   logic [SUM_W-1:0] next_sum;
   logic [CNT_W:0]   next_count;
   logic [CNT_W-1:0] target;
   logic             complete;

   // each beat can push at most one job, so a free slot is all we need
   assign req.ready = !q_stat.full;
   assign take      = req.valid && req.ready;
   assign in_range  = int'(req.channel) < SENSOR_COUNT;

   always_comb begin
      new_group = (count_ff == '0) || (req.channel != chan_ff) || (req.phase != phase_ff);
      if (new_group) begin
         next_sum   = SUM_W'(req.adc_sample);
         next_count = (CNT_W+1)'(1);
      end else begin
         next_sum   = sum_ff + SUM_W'(req.adc_sample);
         next_count = (CNT_W+1)'(count_ff) + (CNT_W+1)'(1);
      end
      target = (req.phase == PH_ACTIVE) ? cfg.active_count : cfg.ambient_count;
      if (target == '0) begin
         target = CNT_W'(1);
      end
      complete = next_count >= (CNT_W+1)'(target);
   end

   assign push              = take && in_range && complete;
   assign push_job.channel  = req.channel;
   assign push_job.phase    = req.phase;
   assign push_job.sum      = next_sum;
   assign push_job.count    = next_count[CNT_W-1:0];

   always_comb begin
      chan_in  = chan_ff;
      phase_in = phase_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      if (take && in_range) begin
         chan_in  = req.channel;
         phase_in = req.phase;
         if (complete) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = next_sum;
            count_in = next_count[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff  <= '0;
         phase_ff <= PH_AMBIENT;
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         chan_ff  <= chan_in;
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/core/irwall_queue.sv
// Short FIFO of completed groups between front and back end.
// Depends on irwall_pkg for the job and status types.
module irwall_queue import irwall_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  job_type    push_job,
   input  logic       pop,
   output job_type    pop_job,
   output q_stat_type q_stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W_Q = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W_Q-1:0] fill_ff,   fill_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign q_stat.full  = fill_ff == CNT_W_Q'(DEPTH);
   assign q_stat.empty = fill_ff == '0;
   assign pop_job      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W_Q'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W_Q'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/core/irwall_back.sv
// Back end: serial divide of a group sum, ambient subtraction, EMA update,
// wall decision and the result register. Depends on irwall_pkg, irwall_rsp_if.
module irwall_back import irwall_pkg::*; #(
   parameter int SENSOR_COUNT = DEF_SENSOR_COUNT
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  job_type      job,
   input  q_stat_type   q_stat,
   output logic         pop,
   irwall_rsp_if.source rsp
);

   localparam int IDX_W  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
   localparam int STEP_W = $clog2(SUM_W);
   localparam int PROD_W = ALPHA_W + ADC_BITS;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [CH_W-1:0]     ch_ff;
   logic                ph_ff;
   logic [CNT_W-1:0]    div_ff;
   logic [CNT_W-1:0]    rem_ff;
   logic [SUM_W-1:0]    quo_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [PROD_W-1:0]   prod_new_ff;
   logic [PROD_W-1:0]   prod_old_ff;
   logic [ADC_BITS-1:0] amb_ff;
   logic [ADC_BITS-1:0] ambient_store_ff  [SENSOR_COUNT];
   logic [ADC_BITS-1:0] filtered_store_ff [SENSOR_COUNT];

   logic                rsp_valid_ff;
   logic [CH_W-1:0]     rsp_ch_ff;
   logic [ADC_BITS-1:0] rsp_amb_ff;
   logic [ADC_BITS-1:0] rsp_raw_ff;
   logic [ADC_BITS-1:0] rsp_filt_ff;
   logic                rsp_wall_ff;

   logic [IDX_W-1:0]    idx;
   logic [CNT_W:0]      shifted;
   logic                ge;
   logic [CNT_W:0]      diff;
   logic [ADC_BITS-1:0] mean;
   logic [ADC_BITS-1:0] amb_rd;
   logic [ADC_BITS-1:0] old_rd;
   logic [ADC_BITS-1:0] signal;
   logic [ALPHA_W-1:0]  alpha;
   logic [PROD_W:0]     ema_sum;
   logic [ADC_BITS-1:0] filt;
   logic                out_free;
   logic                load_rsp;

   function automatic logic wall_flag(input logic [CH_W-1:0] ch,
                                      input logic [ADC_BITS-1:0] level,
                                      input cfg_type c);
      localparam int LVL_W = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;
      logic hit;
      case (ch)
         CH_FRONT:          hit = LVL_W'(level) >= LVL_W'(c.front_thr);
         CH_RIGHT, CH_LEFT: hit = LVL_W'(level) >= LVL_W'(c.side_thr);
         default:           hit = 1'b0;
      endcase
      return hit;
   endfunction

   assign idx  = ch_ff[IDX_W-1:0];
   assign mean = quo_ff[ADC_BITS-1:0];

   // restoring divide, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign ge      = shifted >= {1'b0, div_ff};

   assign amb_rd = ambient_store_ff[idx];
   assign old_rd = filtered_store_ff[idx];
   assign signal = (mean > amb_rd) ? mean - amb_rd : '0;
   assign alpha  = (cfg.ema_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.ema_alpha;

   assign ema_sum = (PROD_W+1)'(prod_new_ff) + (PROD_W+1)'(prod_old_ff);
   assign filt    = ema_sum[ADC_BITS+7:8];

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign pop      = (state_ff == ST_IDLE) && !q_stat.empty;
   assign load_rsp = (state_ff == ST_FIN) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (!q_stat.empty) state_in = ST_DIV;
         ST_DIV:  if (step_ff == '0) state_in = ST_MUL;
         ST_MUL:  state_in = (ph_ff == PH_ACTIVE) ? ST_FIN : ST_IDLE;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            ambient_store_ff[i]  <= '0;
            filtered_store_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_MUL && ph_ff == PH_AMBIENT) begin
            ambient_store_ff[idx] <= mean;
         end
         if (load_rsp) begin
            filtered_store_ff[idx] <= filt;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            ch_ff   <= job.channel;
            ph_ff   <= job.phase;
            div_ff  <= job.count;
            rem_ff  <= '0;
            quo_ff  <= job.sum;
            step_ff <= STEP_W'(SUM_W - 1);
         end
         ST_DIV: begin
            rem_ff  <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            quo_ff  <= {quo_ff[SUM_W-2:0], ge};
            step_ff <= step_ff - STEP_W'(1);
         end
         ST_MUL: begin
            amb_ff      <= amb_rd;
            prod_new_ff <= PROD_W'(alpha) * PROD_W'(signal);
            prod_old_ff <= PROD_W'(ALPHA_ONE - alpha) * PROD_W'(old_rd);
         end
         default: ;
      endcase
      if (load_rsp) begin
         rsp_ch_ff   <= ch_ff;
         rsp_amb_ff  <= amb_ff;
         rsp_raw_ff  <= mean;
         rsp_filt_ff <= filt;
         rsp_wall_ff <= wall_flag(ch_ff, filt, cfg);
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.out_channel    = rsp_ch_ff;
   assign rsp.ambient_level  = rsp_amb_ff;
   assign rsp.raw_level      = rsp_raw_ff;
   assign rsp.filtered_level = rsp_filt_ff;
   assign rsp.wall_seen      = rsp_wall_ff;

endmodule

FILE: rtl/core/ir_ambient_reject_ema_wall_detect_unit.sv
// Top level of the ambient-reject proximity filter: register file and the
// front end, group queue and back end. Depends on irwall_pkg, irwall_if.
//
// Usage:
//   req_bus carries one converter sample per beat, tagged with sensor channel
//   and phase (LED off / LED on). Runs of equal channel and phase are summed
//   until the configured count for that phase is reached; a different tag
//   restarts the run. Samples for a channel beyond the sensor count are
//   taken and dropped.
//   rsp_bus gives one beat per completed LED-on group: ambient, raw mean,
//   filtered level and wall flag. LED-off groups only update the ambient level.
//   csr_* writes a register; write only while the block is idle.
// Timing:
//   With the back end idle, the result of a completing LED-on sample passes the
//   group queue, the divide, multiply and finish states and the result register
//   before it is valid on rsp_bus. The back end works on one group at a time,
//   dividing its sum by its count one bit per cycle, and pops another group
//   only when idle. Samples are taken one per cycle while the group queue has room.
// Reset clears registers to defaults, drops any open group, queued groups and
// the pending result, and zeroes the per-sensor ambient and filtered levels.
// A stall on rsp_bus holds the result; new samples are taken until the queue fills.
module ir_ambient_reject_ema_wall_detect_unit import irwall_pkg::*; #(
   parameter int SENSOR_COUNT = DEF_SENSOR_COUNT,
   parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   irwall_req_if.sink           req_bus,
   irwall_rsp_if.source         rsp_bus,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cfg_type    cfg_ff;
   q_stat_type q_stat;
   logic       push;
   logic       pop;
   job_type    push_job;
   job_type    pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ambient_count <= RST_AMBIENT_COUNT;
         cfg_ff.active_count  <= RST_ACTIVE_COUNT;
         cfg_ff.ema_alpha     <= RST_EMA_ALPHA;
         cfg_ff.front_thr     <= RST_FRONT_THR;
         cfg_ff.side_thr      <= RST_SIDE_THR;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_AMBIENT_COUNT: cfg_ff.ambient_count <= csr_wdata[CNT_W-1:0];
            REG_ACTIVE_COUNT:  cfg_ff.active_count  <= csr_wdata[CNT_W-1:0];
            REG_EMA_ALPHA:     cfg_ff.ema_alpha     <= csr_wdata[ALPHA_W-1:0];
            REG_FRONT_THR:     cfg_ff.front_thr     <= csr_wdata[THR_W-1:0];
            REG_SIDE_THR:      cfg_ff.side_thr      <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   irwall_front #(.SENSOR_COUNT(SENSOR_COUNT)) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req      (req_bus),
      .q_stat   (q_stat),
      .push     (push),
      .push_job (push_job)
   );

   irwall_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .q_stat   (q_stat)
   );

   irwall_back #(.SENSOR_COUNT(SENSOR_COUNT)) u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .job    (pop_job),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp    (rsp_bus)
   );

endmodule

FILE: rtl/core/irwall_checker.sv
// Port-level checks on the result channel of the proximity filter, bound to
// the top level. Depends on irwall_pkg for channel codes.
module irwall_checker import irwall_pkg::*; #(
   parameter int SENSOR_COUNT = DEF_SENSOR_COUNT
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [CH_W-1:0]     out_channel,
   input logic [ADC_BITS-1:0] filtered_level,
   input logic                wall_seen
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_channel)
         && $stable(filtered_level) && $stable(wall_seen))
      else $error("result beat changed under stall");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_top_no_wall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (out_channel == CH_TOP_LEFT || out_channel == CH_TOP_RIGHT)
         |-> !wall_seen)
      else $error("wall flag on a top sensor");

   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(out_channel) < SENSOR_COUNT)
      else $error("result for a sensor beyond the sensor count");

endmodule

bind ir_ambient_reject_ema_wall_detect_unit irwall_checker #(
   .SENSOR_COUNT(SENSOR_COUNT)
) u_irwall_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .out_channel    (rsp_bus.out_channel),
   .filtered_level (rsp_bus.filtered_level),
   .wall_seen      (rsp_bus.wall_seen)
);
